// ----- design/nll_pkg.sv -----
// Shared types, codes and character helpers for the number literal lexer.
package nll_pkg;

  localparam int MAX_LEN_DEF = 255;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_ZERO,
    PH_INT,
    PH_FRAC,
    PH_EXPM,
    PH_EXPS,
    PH_EXPD
  } phase_t;

  typedef enum logic [1:0] {
    RX_BIN,
    RX_OCT,
    RX_DEC,
    RX_HEX
  } radix_t;

  typedef enum logic [3:0] {
    ST_OK,
    ST_EMPTY,
    ST_UNDERSCORE,
    ST_P_NON_HEX,
    ST_BAD_CHAR,
    ST_BAD_DIGIT,
    ST_FLOAT_BASE,
    ST_HEX_NEEDS_P,
    ST_EXP_BASE,
    ST_EXP_NO_DIGITS,
    ST_BAD_EXP_CHAR,
    ST_NO_DIGITS,
    ST_TOO_LONG
  } status_t;

  localparam logic [1:0] MK_NONE  = 2'd0;
  localparam logic [1:0] MK_E     = 2'd1;
  localparam logic [1:0] MK_P     = 2'd2;
  localparam logic [1:0] SG_NONE  = 2'd0;
  localparam logic [1:0] SG_PLUS  = 2'd1;
  localparam logic [1:0] SG_MINUS = 2'd2;

  localparam logic [7:0] CH_0     = "0";
  localparam logic [7:0] CH_LX    = "x";
  localparam logic [7:0] CH_UX    = "X";
  localparam logic [7:0] CH_LB    = "b";
  localparam logic [7:0] CH_UB    = "B";
  localparam logic [7:0] CH_LO    = "o";
  localparam logic [7:0] CH_UO    = "O";
  localparam logic [7:0] CH_LE    = "e";
  localparam logic [7:0] CH_UE    = "E";
  localparam logic [7:0] CH_LP    = "p";
  localparam logic [7:0] CH_UP    = "P";
  localparam logic [7:0] CH_US    = "_";
  localparam logic [7:0] CH_DOT   = ".";
  localparam logic [7:0] CH_PLUS  = "+";
  localparam logic [7:0] CH_MINUS = "-";

  typedef struct packed {
    logic [7:0] ch;
    logic       at_end;
  } in_t;

  typedef struct packed {
    status_t    status;
    radix_t     radix;
    logic [1:0] prefix_len;
    logic [7:0] int_len;
    logic       has_point;
    logic [7:0] frac_len;
    logic [1:0] exp_marker;
    logic [1:0] exp_sign;
    logic [7:0] exp_len;
    logic [7:0] consumed_len;
  } out_t;

  function automatic logic [4:0] radix_base(radix_t rx);
    logic [4:0] b;
    case (rx)
      RX_BIN:  b = 5'd2;
      RX_OCT:  b = 5'd8;
      RX_DEC:  b = 5'd10;
      RX_HEX:  b = 5'd16;
      default: b = 5'd10;
    endcase
    return b;
  endfunction

  function automatic logic char_is_dec(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic char_is_letter(logic [7:0] c);
    return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex_alpha(logic [7:0] c);
    return ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // Digit value of 0-9, a-f, A-F; other codes give 31.
  function automatic logic [4:0] digit_val(logic [7:0] c);
    logic [4:0] v;
    if ((c >= "0") && (c <= "9")) begin
      v = 5'(c - "0");
    end else if ((c >= "a") && (c <= "f")) begin
      v = 5'(c - "a") + 5'd10;
    end else if ((c >= "A") && (c <= "F")) begin
      v = 5'(c - "A") + 5'd10;
    end else begin
      v = 5'd31;
    end
    return v;
  endfunction

endpackage

// ----- design/nll_core.sv -----
// Lexer state registers and the per-character step logic.
module nll_core #(
  parameter int MAX_LEN = nll_pkg::MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  nll_pkg::in_t  item,
  output logic          res_vld,
  output nll_pkg::out_t res
);

  localparam int CW = $clog2(MAX_LEN + 1);
  localparam logic [CW-1:0] LEN_MAX = CW'(MAX_LEN);
  localparam logic [CW-1:0] ONE = CW'(1);

  nll_pkg::phase_t  phase_r, phase_nxt, phase_w;
  nll_pkg::radix_t  radix_r, radix_nxt, radix_w;
  logic             octal_r, octal_nxt, octal_w;
  logic             seg_start_r, seg_start_nxt, seg_start_w;
  logic             last_us_r, last_us_nxt, last_us_w;
  logic [1:0]       pre_r, pre_nxt, pre_w;
  logic [CW-1:0]    int_r, int_nxt, int_w;
  logic [CW-1:0]    frac_r, frac_nxt, frac_w;
  logic [CW-1:0]    exp_r, exp_nxt, exp_w;
  logic             point_r, point_nxt, point_w;
  logic [1:0]       marker_r, marker_nxt, marker_w;
  logic [1:0]       sign_r, sign_nxt, sign_w;
  logic [CW-1:0]    total_r, total_nxt, total_w;

  logic             emit, clr;
  nll_pkg::status_t code;
  logic             run_body, run_after, run_exp, exp_fin, fin;

  logic [7:0]       ch;
  logic             at_end, dig, alpha, hexa, is_e, is_p, is_pfx, full;
  nll_pkg::radix_t  pfx_rx;

  assign ch     = item.ch;
  assign at_end = item.at_end;
  assign dig    = nll_pkg::char_is_dec(ch);
  assign alpha  = nll_pkg::char_is_letter(ch);
  assign hexa   = nll_pkg::is_hex_alpha(ch);
  assign is_e   = (ch == nll_pkg::CH_LE) || (ch == nll_pkg::CH_UE);
  assign is_p   = (ch == nll_pkg::CH_LP) || (ch == nll_pkg::CH_UP);
  assign is_pfx = (ch == nll_pkg::CH_LX) || (ch == nll_pkg::CH_UX) ||
                  (ch == nll_pkg::CH_LB) || (ch == nll_pkg::CH_UB) ||
                  (ch == nll_pkg::CH_LO) || (ch == nll_pkg::CH_UO);
  assign pfx_rx = ((ch == nll_pkg::CH_LX) || (ch == nll_pkg::CH_UX)) ? nll_pkg::RX_HEX :
                  ((ch == nll_pkg::CH_LB) || (ch == nll_pkg::CH_UB)) ? nll_pkg::RX_BIN :
                  nll_pkg::RX_OCT;
  assign full   = (total_r >= LEN_MAX);

  // Working copy of the state after one character, plus emit decision.
  always_comb begin
    phase_w     = phase_r;
    radix_w     = radix_r;
    octal_w     = octal_r;
    seg_start_w = seg_start_r;
    last_us_w   = last_us_r;
    pre_w       = pre_r;
    int_w       = int_r;
    frac_w      = frac_r;
    exp_w       = exp_r;
    point_w     = point_r;
    marker_w    = marker_r;
    sign_w      = sign_r;
    total_w     = total_r;
    emit        = 1'b0;
    clr         = 1'b0;
    code        = nll_pkg::ST_OK;
    run_body    = 1'b0;
    run_after   = 1'b0;
    run_exp     = 1'b0;
    exp_fin     = 1'b0;
    fin         = 1'b0;

    case (phase_r)
      nll_pkg::PH_IDLE: begin
        if (at_end) begin
          emit = 1'b1; code = nll_pkg::ST_EMPTY;
        end else if (ch == nll_pkg::CH_0) begin
          if (full) begin
            emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
          end else begin
            total_w = total_w + ONE;
            phase_w = nll_pkg::PH_ZERO;
          end
        end else begin
          phase_w  = nll_pkg::PH_INT;
          run_body = 1'b1;
        end
      end
      nll_pkg::PH_ZERO: begin
        if (at_end) begin
          int_w   = ONE;
          radix_w = nll_pkg::RX_DEC;
          fin     = 1'b1;
        end else if (is_pfx) begin
          if (full) begin
            emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
          end else begin
            total_w     = total_w + ONE;
            radix_w     = pfx_rx;
            pre_w       = 2'd2;
            seg_start_w = 1'b0;
            phase_w     = nll_pkg::PH_INT;
          end
        end else begin
          seg_start_w = 1'b0;
          phase_w     = nll_pkg::PH_INT;
          if ((ch == nll_pkg::CH_US) || dig) begin
            radix_w = nll_pkg::RX_OCT;
            octal_w = 1'b1;
            pre_w   = 2'd1;
          end else begin
            radix_w = nll_pkg::RX_DEC;
            int_w   = ONE;
          end
          run_body = 1'b1;
        end
      end
      nll_pkg::PH_INT, nll_pkg::PH_FRAC: begin
        if (at_end) begin
          run_after = 1'b1;
        end else begin
          run_body = 1'b1;
        end
      end
      nll_pkg::PH_EXPM: begin
        if (at_end) begin
          emit = 1'b1; code = nll_pkg::ST_EXP_NO_DIGITS;
        end else begin
          if (octal_w) begin
            int_w   = int_w + CW'(pre_w);
            pre_w   = 2'd0;
            octal_w = 1'b0;
            radix_w = nll_pkg::RX_DEC;
          end
          if ((radix_w != nll_pkg::RX_DEC) && (radix_w != nll_pkg::RX_HEX)) begin
            emit = 1'b1; code = nll_pkg::ST_EXP_BASE;
          end else if ((ch == nll_pkg::CH_PLUS) || (ch == nll_pkg::CH_MINUS)) begin
            if (full) begin
              emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
            end else begin
              total_w = total_w + ONE;
              sign_w  = (ch == nll_pkg::CH_PLUS) ? nll_pkg::SG_PLUS : nll_pkg::SG_MINUS;
              phase_w = nll_pkg::PH_EXPS;
            end
          end else begin
            phase_w = nll_pkg::PH_EXPD;
            run_exp = 1'b1;
          end
        end
      end
      nll_pkg::PH_EXPS: begin
        if (at_end) begin
          emit = 1'b1; code = nll_pkg::ST_EXP_NO_DIGITS;
        end else begin
          phase_w = nll_pkg::PH_EXPD;
          run_exp = 1'b1;
        end
      end
      nll_pkg::PH_EXPD: begin
        run_exp = 1'b1;
      end
      default: begin
        clr = 1'b1;
      end
    endcase

    // Character inside the integer or fraction part.
    if (run_body) begin
      if (ch == nll_pkg::CH_US) begin
        if (seg_start_w || last_us_w) begin
          emit = 1'b1; code = nll_pkg::ST_UNDERSCORE;
        end else if (full) begin
          emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
        end else begin
          total_w   = total_w + ONE;
          last_us_w = 1'b1;
          if (phase_w == nll_pkg::PH_INT) begin
            int_w = int_w + ONE;
          end else begin
            frac_w = frac_w + ONE;
          end
        end
      end else if (is_e && ((radix_w == nll_pkg::RX_DEC) || (radix_w == nll_pkg::RX_OCT))) begin
        run_after = 1'b1;
      end else if (is_p) begin
        if (radix_w == nll_pkg::RX_HEX) begin
          run_after = 1'b1;
        end else begin
          emit = 1'b1; code = nll_pkg::ST_P_NON_HEX;
        end
      end else if (dig || hexa) begin
        if (nll_pkg::digit_val(ch) >= nll_pkg::radix_base(radix_w)) begin
          emit = 1'b1; code = nll_pkg::ST_BAD_DIGIT;
        end else if (full) begin
          emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
        end else begin
          total_w     = total_w + ONE;
          last_us_w   = 1'b0;
          seg_start_w = 1'b0;
          if (phase_w == nll_pkg::PH_INT) begin
            int_w = int_w + ONE;
          end else begin
            frac_w = frac_w + ONE;
          end
        end
      end else if (alpha) begin
        emit = 1'b1; code = nll_pkg::ST_BAD_CHAR;
      end else begin
        run_after = 1'b1;
      end
    end

    // End of an integer or fraction segment.
    if (run_after) begin
      if (last_us_w) begin
        emit = 1'b1; code = nll_pkg::ST_UNDERSCORE;
      end else begin
        seg_start_w = 1'b1;
        last_us_w   = 1'b0;
        if (at_end) begin
          fin = 1'b1;
        end else if ((ch == nll_pkg::CH_DOT) && (phase_w == nll_pkg::PH_INT)) begin
          point_w = 1'b1;
          if (octal_w) begin
            int_w   = int_w + CW'(pre_w);
            pre_w   = 2'd0;
            octal_w = 1'b0;
            radix_w = nll_pkg::RX_DEC;
          end
          if ((radix_w != nll_pkg::RX_DEC) && (radix_w != nll_pkg::RX_HEX)) begin
            emit = 1'b1; code = nll_pkg::ST_FLOAT_BASE;
          end else if (full) begin
            emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
          end else begin
            total_w = total_w + ONE;
            phase_w = nll_pkg::PH_FRAC;
          end
        end else if (is_e) begin
          if (radix_w == nll_pkg::RX_HEX) begin
            emit = 1'b1; code = nll_pkg::ST_HEX_NEEDS_P;
          end else if (full) begin
            emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
          end else begin
            total_w  = total_w + ONE;
            marker_w = nll_pkg::MK_E;
            phase_w  = nll_pkg::PH_EXPM;
          end
        end else if (is_p) begin
          if (radix_w != nll_pkg::RX_HEX) begin
            emit = 1'b1; code = nll_pkg::ST_P_NON_HEX;
          end else if (full) begin
            emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
          end else begin
            total_w  = total_w + ONE;
            marker_w = nll_pkg::MK_P;
            phase_w  = nll_pkg::PH_EXPM;
          end
        end else begin
          fin = 1'b1;
        end
      end
    end

    // Exponent digits.
    if (run_exp) begin
      if (at_end) begin
        exp_fin = 1'b1;
      end else if (ch == nll_pkg::CH_US) begin
        if (seg_start_w || last_us_w) begin
          emit = 1'b1; code = nll_pkg::ST_UNDERSCORE;
        end else if (full) begin
          emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
        end else begin
          total_w   = total_w + ONE;
          last_us_w = 1'b1;
          exp_w     = exp_w + ONE;
        end
      end else if (dig) begin
        if (full) begin
          emit = 1'b1; code = nll_pkg::ST_TOO_LONG;
        end else begin
          total_w     = total_w + ONE;
          last_us_w   = 1'b0;
          seg_start_w = 1'b0;
          exp_w       = exp_w + ONE;
        end
      end else if ((ch == nll_pkg::CH_DOT) || alpha) begin
        emit = 1'b1; code = nll_pkg::ST_BAD_EXP_CHAR;
      end else begin
        exp_fin = 1'b1;
      end
    end

    if (exp_fin) begin
      if (last_us_w) begin
        emit = 1'b1; code = nll_pkg::ST_UNDERSCORE;
      end else if (exp_w == '0) begin
        emit = 1'b1; code = nll_pkg::ST_EXP_NO_DIGITS;
      end else begin
        fin = 1'b1;
      end
    end

    if (fin) begin
      emit = 1'b1;
      code = ((int_w == '0) && (frac_w == '0)) ? nll_pkg::ST_NO_DIGITS : nll_pkg::ST_OK;
    end
  end

  // Next state: a finished literal returns everything to reset.
  always_comb begin
    if (emit || clr) begin
      phase_nxt     = nll_pkg::PH_IDLE;
      radix_nxt     = nll_pkg::RX_DEC;
      octal_nxt     = 1'b0;
      seg_start_nxt = 1'b1;
      last_us_nxt   = 1'b0;
      pre_nxt       = 2'd0;
      int_nxt       = '0;
      frac_nxt      = '0;
      exp_nxt       = '0;
      point_nxt     = 1'b0;
      marker_nxt    = nll_pkg::MK_NONE;
      sign_nxt      = nll_pkg::SG_NONE;
      total_nxt     = '0;
    end else begin
      phase_nxt     = phase_w;
      radix_nxt     = radix_w;
      octal_nxt     = octal_w;
      seg_start_nxt = seg_start_w;
      last_us_nxt   = last_us_w;
      pre_nxt       = pre_w;
      int_nxt       = int_w;
      frac_nxt      = frac_w;
      exp_nxt       = exp_w;
      point_nxt     = point_w;
      marker_nxt    = marker_w;
      sign_nxt      = sign_w;
      total_nxt     = total_w;
    end
  end

  // Result fields.
  always_comb begin
    res_vld = step && emit;
    res     = '0;
    res.status       = code;
    res.consumed_len = 8'(total_w);
    if (code == nll_pkg::ST_OK) begin
      res.radix      = radix_w;
      res.prefix_len = pre_w;
      res.int_len    = 8'(int_w);
      res.has_point  = point_w;
      res.frac_len   = 8'(frac_w);
      res.exp_marker = marker_w;
      res.exp_sign   = sign_w;
      res.exp_len    = 8'(exp_w);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= nll_pkg::PH_IDLE;
      radix_r     <= nll_pkg::RX_DEC;
      octal_r     <= 1'b0;
      seg_start_r <= 1'b1;
      last_us_r   <= 1'b0;
      pre_r       <= 2'd0;
      int_r       <= '0;
      frac_r      <= '0;
      exp_r       <= '0;
      point_r     <= 1'b0;
      marker_r    <= nll_pkg::MK_NONE;
      sign_r      <= nll_pkg::SG_NONE;
      total_r     <= '0;
    end else if (step) begin
      phase_r     <= phase_nxt;
      radix_r     <= radix_nxt;
      octal_r     <= octal_nxt;
      seg_start_r <= seg_start_nxt;
      last_us_r   <= last_us_nxt;
      pre_r       <= pre_nxt;
      int_r       <= int_nxt;
      frac_r      <= frac_nxt;
      exp_r       <= exp_nxt;
      point_r     <= point_nxt;
      marker_r    <= marker_nxt;
      sign_r      <= sign_nxt;
      total_r     <= total_nxt;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= LEN_MAX)
    else $error("length count above limit");

  a_emit_resets: assert property (@(posedge clk) disable iff (!rst_n)
    step && res_vld |=> (phase_r == nll_pkg::PH_IDLE) && (total_r == '0))
    else $error("state not cleared after result");

  a_idle_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == nll_pkg::PH_IDLE) |-> (total_r == '0) && (pre_r == 2'd0) && !octal_r)
    else $error("idle with leftover literal state");

endmodule

// ----- design/number_literal_lexer.sv -----
// Number literal lexer top level: input register, lexer core, result register.
// A character taken into the input register is lexed by the core; its result, if any,
//   is written to the result register and offered on out_valid.
// Throughput: one character per cycle unless out_stall holds back a pending result.
// Reset: rst_n low at a clock edge empties both registers and returns the lexer to
//   the start of a new literal.
module number_literal_lexer #(
  parameter int MAX_LEN = nll_pkg::MAX_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  nll_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output nll_pkg::out_t out_data
);

  logic          in_vld_r;
  nll_pkg::in_t  in_data_r;
  logic          out_vld_r;
  nll_pkg::out_t out_data_r;
  logic          advance;
  logic          core_vld;
  nll_pkg::out_t core_res;

  assign advance   = !out_vld_r || !out_stall;
  assign in_stall  = in_vld_r && !advance;
  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

  nll_core #(
    .MAX_LEN(MAX_LEN)
  ) u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (in_vld_r && advance),
    .item   (in_data_r),
    .res_vld(core_vld),
    .res    (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      in_data_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= core_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && core_vld) begin
      out_data_r <= core_res;
    end
  end

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && !advance |=> in_vld_r && $stable(in_data_r))
    else $error("held request lost");

endmodule
